// ===== sv/rde_pkg.sv =====
// shared types, constants and symbol lookup for the radix digit emitter
package rde_pkg;

    localparam int MAX_SYMBOLS = 16;
    localparam int MAG_W = 32;
    localparam int NUM_DIGITS = 32;
    localparam int DIGIT_W = 4;
    localparam int NDIG_W = 6;
    localparam int POS_W = 5;
    localparam int RADIX_W = 5;
    localparam int CHAR_W = 8;
    localparam int SYM_W = 64;
    localparam int CFG_IDX_W = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

    localparam logic [RADIX_W-1:0] BASE_SIZE_RESET    = 5'd10;
    localparam logic [SYM_W-1:0]   SYMBOLS_LOW_RESET  = 64'd4050765991979987505;
    localparam logic [SYM_W-1:0]   SYMBOLS_HIGH_RESET = 64'd14648;

    localparam logic [RADIX_W-1:0] RADIX_CAP = RADIX_W'(MAX_SYMBOLS);
    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_DEL   = 8'd127;

    typedef logic [DIGIT_W-1:0] digit_t;

    typedef struct packed {
        digit_t [NUM_DIGITS-1:0] digits;
        logic [NDIG_W-1:0]       ndig;
        logic                    neg;
        logic                    invalid;
    } rde_rec_t;

    function automatic logic [CHAR_W-1:0] sym_at(
        input logic [SYM_W-1:0]   lo,
        input logic [SYM_W-1:0]   hi,
        input logic [DIGIT_W-1:0] k
    );
        logic [SYM_W-1:0] word;
        word = k[DIGIT_W-1] ? hi : lo;
        return word[{k[DIGIT_W-2:0], 3'b000} +: CHAR_W];
    endfunction

endpackage

// ===== sv/radix_digit_emitter.sv =====
// top level of the radix digit emitter: configuration registers and the front, queue and back
// Prints a signed 32-bit value as text in the radix set by base_size, using the symbol bytes in
// symbols_low/symbols_high. Each character leaves on character with strobe high for one cycle;
// a negative value starts with '-', the final character carries last, and a base that fails
// the check gives one item with base_invalid set and character zero. The receiver cannot stall,
// so characters of a run come out on consecutive cycles. The front converts a value bit-serially,
// one magnitude bit per cycle (it skips the conversion when the base is invalid), and takes no new
// value until it has pushed the last one and is idle again; the back emits one character per
// cycle, up to 33 for a value, and a two-item queue between them lets the next value convert
// while the previous one is still being emitted. The first character leaves through the back's
// output registers once its record has passed the queue. Configuration writes take effect at
// once; the user must make them only while the block is idle, as the block does not enforce it.
module radix_digit_emitter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic signed [31:0]             value,
    output logic                           busy,
    input  logic                           wr_en,
    input  logic [rde_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [rde_pkg::SYM_W-1:0]      wr_data,
    output logic                           strobe,
    output logic [rde_pkg::CHAR_W-1:0]     character,
    output logic                           last,
    output logic                           base_invalid
);
    import rde_pkg::*;

    logic [RADIX_W-1:0] base_size_reg;
    logic [SYM_W-1:0]   symbols_low_reg;
    logic [SYM_W-1:0]   symbols_high_reg;
    logic [RADIX_W-1:0] radix;

    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    rde_rec_t           front_rec;
    rde_rec_t           head_rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_size_reg    <= BASE_SIZE_RESET;
            symbols_low_reg  <= SYMBOLS_LOW_RESET;
            symbols_high_reg <= SYMBOLS_HIGH_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_BASE_SIZE:    base_size_reg    <= wr_data[RADIX_W-1:0];
                REG_SYMBOLS_LOW:  symbols_low_reg  <= wr_data;
                REG_SYMBOLS_HIGH: symbols_high_reg <= wr_data;
                default:          base_size_reg    <= base_size_reg;
            endcase
        end
    end

    // radix saturates at the symbol table size
    assign radix = (base_size_reg > RADIX_CAP) ? RADIX_CAP : base_size_reg;

    rde_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .value  (value),
        .busy   (busy),
        .radix  (radix),
        .sym_lo (symbols_low_reg),
        .sym_hi (symbols_high_reg),
        .full   (q_full),
        .push   (q_push),
        .rec    (front_rec)
    );

    rde_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .rec_in  (front_rec),
        .full    (q_full),
        .pop     (q_pop),
        .rec_out (head_rec),
        .empty   (q_empty)
    );

    rde_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (q_empty),
        .rec          (head_rec),
        .pop          (q_pop),
        .sym_lo       (symbols_low_reg),
        .sym_hi       (symbols_high_reg),
        .strobe       (strobe),
        .character    (character),
        .last         (last),
        .base_invalid (base_invalid)
    );

`ifndef SYNTHESIS
    a_invalid_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && base_invalid) |-> (last && character == CHAR_NUL))
        else $error("invalid-base item not a lone null character");
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> strobe)
        else $error("gap inside a character run");
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("front not busy after taking an item");
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !base_invalid && character == CHAR_MINUS) |-> !last)
        else $error("minus sign ended a run");
`endif

endmodule

// ===== sv/rde_front.sv =====
// front end: accepts values, checks the base and converts the magnitude bit-serially
module rde_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [31:0]              value,
    output logic                            busy,
    input  logic [rde_pkg::RADIX_W-1:0]     radix,
    input  logic [rde_pkg::SYM_W-1:0]       sym_lo,
    input  logic [rde_pkg::SYM_W-1:0]       sym_hi,
    input  logic                            full,
    output logic                            push,
    output rde_pkg::rde_rec_t               rec
);
    import rde_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_CONV = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [POS_W-1:0]        bitcnt_reg, bitcnt_next;
    logic [MAG_W-1:0]        mag_reg, mag_next;
    digit_t [NUM_DIGITS-1:0] digits_reg, digits_next;
    logic [NDIG_W-1:0]       ndig_reg, ndig_next;
    logic                    neg_reg, neg_next;
    logic                    inv_reg, inv_next;

    logic                    base_bad;
    logic [MAG_W-1:0]        gen_v, any_v;
    logic [MAG_W:0]          csum;
    logic [MAG_W:0]          carry;
    digit_t [NUM_DIGITS-1:0] digits_step;
    logic [MAG_W-1:0]        raw_mag;

    // base check: radix, forbidden bytes, duplicates
    always_comb
    begin
        logic [CHAR_W-1:0] ch;
        ch = '0;
        base_bad = (radix < RADIX_MIN);
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            if (RADIX_W'(i) < radix)
            begin
                ch = sym_at(sym_lo, sym_hi, DIGIT_W'(i));
                if (ch == CHAR_PLUS || ch == CHAR_MINUS || ch <= CHAR_SPACE || ch >= CHAR_DEL)
                begin
                    base_bad = 1'b1;
                end
                for (int j = i + 1; j < MAX_SYMBOLS; j++)
                begin
                    if (RADIX_W'(j) < radix && ch == sym_at(sym_lo, sym_hi, DIGIT_W'(j)))
                    begin
                        base_bad = 1'b1;
                    end
                end
            end
        end
    end

    // one doubling step of the digit vector, carries resolved by one wide add
    always_comb
    begin
        logic [RADIX_W-1:0] t;
        t = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            gen_v[i] = ({digits_reg[i], 1'b0} >= radix);
            any_v[i] = gen_v[i] || ({digits_reg[i], 1'b1} == radix);
        end
        csum = {1'b0, any_v} + {1'b0, gen_v} + (MAG_W+1)'(mag_reg[MAG_W-1]);
        carry = csum ^ {1'b0, any_v} ^ {1'b0, gen_v};
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            t = {digits_reg[i], carry[i]};
            digits_step[i] = (t >= radix) ? DIGIT_W'(t - radix) : t[DIGIT_W-1:0];
        end
    end

    assign raw_mag = value[31] ? (32'd0 - 32'(value)) : 32'(value);

    always_comb
    begin
        state_next  = state_reg;
        bitcnt_next = bitcnt_reg;
        mag_next    = mag_reg;
        digits_next = digits_reg;
        ndig_next   = ndig_reg;
        neg_next    = neg_reg;
        inv_next    = inv_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    mag_next    = raw_mag;
                    neg_next    = value[31];
                    inv_next    = base_bad;
                    digits_next = '0;
                    ndig_next   = '0;
                    bitcnt_next = '0;
                    state_next  = base_bad ? F_PUSH : F_CONV;
                end
            end
            F_CONV:
            begin
                digits_next = digits_step;
                ndig_next   = ndig_reg + NDIG_W'(carry[ndig_reg]);
                mag_next    = {mag_reg[MAG_W-2:0], 1'b0};
                bitcnt_next = bitcnt_reg + 1'b1;
                if (bitcnt_reg == POS_W'(MAG_W - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            bitcnt_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            bitcnt_reg <= bitcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        digits_reg <= digits_next;
        ndig_reg   <= ndig_next;
        neg_reg    <= neg_next;
        inv_reg    <= inv_next;
    end

    assign busy        = (state_reg != F_IDLE);
    assign push        = (state_reg == F_PUSH) && !full;
    assign rec.digits  = digits_reg;
    assign rec.ndig    = ndig_reg;
    assign rec.neg     = neg_reg;
    assign rec.invalid = inv_reg;

endmodule

// ===== sv/rde_queue.sv =====
// small item queue between the converter and the character emitter
module rde_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rde_pkg::rde_rec_t rec_in,
    output logic              full,
    input  logic              pop,
    output rde_pkg::rde_rec_t rec_out,
    output logic              empty
);
    import rde_pkg::*;

    rde_rec_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rec_out = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= rec_in;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full && !pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue read while empty");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> !empty)
        else $error("queue empty after write");
`endif

endmodule

// ===== sv/rde_back.sv =====
// back end: emits sign and digit symbols, or a null for an invalid base, one character per cycle
module rde_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         empty,
    input  rde_pkg::rde_rec_t            rec,
    output logic                         pop,
    input  logic [rde_pkg::SYM_W-1:0]    sym_lo,
    input  logic [rde_pkg::SYM_W-1:0]    sym_hi,
    output logic                         strobe,
    output logic [rde_pkg::CHAR_W-1:0]   character,
    output logic                         last,
    output logic                         base_invalid
);
    import rde_pkg::*;

    localparam logic B_IDLE = 1'b0;
    localparam logic B_EMIT = 1'b1;

    logic              state_reg, state_next;
    rde_rec_t          rec_reg, rec_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              sign_reg, sign_next;
    logic              strobe_reg;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;
    logic              inv_reg, inv_next;

    logic              emit;
    logic              finishing;
    digit_t            cur_digit;

    assign emit      = (state_reg == B_EMIT);
    assign cur_digit = rec_reg.digits[pos_reg];

    always_comb
    begin
        if (rec_reg.invalid)
        begin
            char_next = CHAR_NUL;
            last_next = 1'b1;
            inv_next  = 1'b1;
        end
        else if (sign_reg)
        begin
            char_next = CHAR_MINUS;
            last_next = 1'b0;
            inv_next  = 1'b0;
        end
        else
        begin
            char_next = sym_at(sym_lo, sym_hi, cur_digit);
            last_next = (pos_reg == '0);
            inv_next  = 1'b0;
        end
    end

    assign finishing = emit && last_next;
    assign pop       = !empty && (!emit || finishing);

    always_comb
    begin
        state_next = state_reg;
        rec_next   = rec_reg;
        pos_next   = pos_reg;
        sign_next  = sign_reg;
        if (pop)
        begin
            state_next = B_EMIT;
            rec_next   = rec;
            sign_next  = rec.neg && !rec.invalid;
            pos_next   = (rec.ndig == '0) ? '0 : POS_W'(rec.ndig - 1'b1);
        end
        else if (emit)
        begin
            if (finishing)
            begin
                state_next = B_IDLE;
            end
            else if (sign_reg)
            begin
                sign_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg  <= rec_next;
        pos_reg  <= pos_next;
        sign_reg <= sign_next;
        char_reg <= char_next;
        last_reg <= last_next;
        inv_reg  <= inv_next;
    end

    assign strobe       = strobe_reg;
    assign character    = char_reg;
    assign last         = last_reg;
    assign base_invalid = inv_reg;

endmodule

// ===== bench/tb_radix_digit_emitter.sv =====
`timescale 1ns / 1ps
// testbench for radix_digit_emitter: directed and random values checked against a text predictor
module tb_radix_digit_emitter;
    import rde_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              fin;
        logic              bad;
    } text_char_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 405;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic signed [31:0]    value;
    logic                  busy;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [SYM_W-1:0]      wr_data;
    logic                  strobe;
    logic [CHAR_W-1:0]     character;
    logic                  last;
    logic                  base_invalid;

    logic [RADIX_W-1:0]    cfg_size;
    logic [SYM_W-1:0]      cfg_lo;
    logic [SYM_W-1:0]      cfg_hi;
    text_char_t            pending_chars[$];
    int                    mismatches = 0;
    int                    values_sent = 0;
    int                    chars_seen = 0;
    int                    invalid_seen = 0;
    int                    configs_used = 0;
    int                    cycles = 0;
    bit                    idle_on = 1'b1;

    radix_digit_emitter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .value        (value),
        .busy         (busy),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .strobe       (strobe),
        .character    (character),
        .last         (last),
        .base_invalid (base_invalid)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d chars still due", cycles,
                     pending_chars.size());
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [CHAR_W-1:0] sym_of(int k);
        return (k < 8) ? cfg_lo[k*8 +: 8] : cfg_hi[(k-8)*8 +: 8];
    endfunction

    function automatic bit base_usable(int r);
        logic [CHAR_W-1:0] c;
        if (r < 2)
            return 1'b0;
        for (int i = 0; i < r; i++)
        begin
            c = sym_of(i);
            if (c == CHAR_PLUS || c == CHAR_MINUS || c <= CHAR_SPACE || c >= CHAR_DEL)
                return 1'b0;
            for (int j = i + 1; j < r; j++)
                if (c == sym_of(j))
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // expected characters of one value in the current base
    function automatic void predict_text(logic [31:0] raw);
        logic [31:0] radix;
        logic [31:0] mag;
        logic [DIGIT_W-1:0] digs[32];
        int nd;
        radix = (cfg_size > RADIX_CAP) ? 32'(RADIX_CAP) : 32'(cfg_size);
        if (!base_usable(int'(radix)))
        begin
            pending_chars.push_back(text_char_t'{CHAR_NUL, 1'b1, 1'b1});
            return;
        end
        mag = raw[31] ? (32'd0 - raw) : raw;
        nd = 0;
        do
        begin
            digs[nd] = DIGIT_W'(mag % radix);
            mag = mag / radix;
            nd++;
        end
        while (mag != 0 && nd < 32);
        if (raw[31])
            pending_chars.push_back(text_char_t'{CHAR_MINUS, 1'b0, 1'b0});
        for (int i = nd - 1; i >= 0; i--)
            pending_chars.push_back(text_char_t'{sym_of(int'(digs[i])), i == 0, 1'b0});
    endfunction

    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && strobe)
        begin
            chars_seen++;
            if (base_invalid)
                invalid_seen++;
            if (pending_chars.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected item at cycle %0d: char %h last %b invalid %b",
                             cycles, character, last, base_invalid);
                mismatches++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (character !== want.ch || last !== want.fin || base_invalid !== want.bad)
                begin
                    if (mismatches < 10)
                        $display("mismatch at cycle %0d: char %h/%h last %b/%b invalid %b/%b",
                                 cycles, character, want.ch, last, want.fin,
                                 base_invalid, want.bad);
                    mismatches++;
                end
            end
        end
    end

    // tasks start and end just after a falling edge
    task automatic send_value(logic [31:0] v);
        start = 1'b1;
        value = v;
        do
            @(posedge clk);
        while (busy);
        predict_text(v);
        values_sent++;
        @(negedge clk);
        start = 1'b0;
        if (idle_on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 13)) @(negedge clk);
    endtask

    task automatic wait_idle();
        while (pending_chars.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SYM_W-1:0] data);
        wr_en = 1'b1;
        wr_index = idx;
        wr_data = data;
        case (idx)
            REG_BASE_SIZE:    cfg_size = data[RADIX_W-1:0];
            REG_SYMBOLS_LOW:  cfg_lo = data;
            REG_SYMBOLS_HIGH: cfg_hi = data;
            default: ;
        endcase
        @(negedge clk);
        wr_en = 1'b0;
    endtask

    task automatic set_base(logic [RADIX_W-1:0] size, logic [SYM_W-1:0] lo,
                            logic [SYM_W-1:0] hi);
        logic [SYM_W-1:0] size_word;
        wait_idle();
        size_word = {$urandom, $urandom};
        size_word[RADIX_W-1:0] = size;
        write_reg(REG_BASE_SIZE, size_word);
        write_reg(REG_SYMBOLS_LOW, lo);
        write_reg(REG_SYMBOLS_HIGH, hi);
        configs_used++;
    endtask

    function automatic logic [SYM_W-1:0] with_byte(logic [SYM_W-1:0] word, int pos,
                                                   logic [7:0] b);
        word[pos*8 +: 8] = b;
        return word;
    endfunction

    function automatic logic [31:0] pick_value(int r);
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, r * r);
            1: v = 32'd0 - $urandom_range(1, r * r);
            2:
            begin
                case ($urandom_range(0, 4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 32'hffff_ffff;
                    3: v = 32'h0;
                    default: v = 32'h1;
                endcase
            end
            3: v = (32'h1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic test_reset_base();
        logic [31:0] vals[10] = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                                  32'd9, 32'd10, 32'hffff_fff6, 32'h5555_5555, 32'haaaa_aaaa};
        foreach (vals[i])
            send_value(vals[i]);
    endtask

    task automatic test_radix_extremes();
        logic [SYM_W-1:0] hex_lo;
        logic [SYM_W-1:0] hex_hi;
        hex_lo = 64'h3736_3534_3332_3130;
        hex_hi = 64'h4645_4443_4241_3938;
        set_base(5'd2, 64'h3130, 64'h0);
        send_value(32'h8000_0000);
        send_value(32'h7fff_ffff);
        send_value(32'hffff_ffff);
        // oversized base saturates to sixteen symbols
        set_base(5'd31, hex_lo, hex_hi);
        send_value(32'h8000_0000);
        send_value(32'hdead_beef);
    endtask

    task automatic test_invalid_bases();
        logic [SYM_W-1:0] hex_lo;
        logic [SYM_W-1:0] hex_hi;
        hex_lo = 64'h3736_3534_3332_3130;
        hex_hi = 64'h4645_4443_4241_3938;
        set_base(5'd0, hex_lo, hex_hi);
        send_value($urandom);
        set_base(5'd1, hex_lo, hex_hi);
        send_value($urandom);
        set_base(5'd10, with_byte(hex_lo, 3, CHAR_PLUS), hex_hi);
        send_value($urandom);
        set_base(5'd10, hex_lo, with_byte(hex_hi, 1, CHAR_MINUS));
        send_value($urandom);
        set_base(5'd10, with_byte(hex_lo, 0, CHAR_SPACE), hex_hi);
        send_value($urandom);
        set_base(5'd16, hex_lo, with_byte(hex_hi, 7, CHAR_DEL));
        send_value($urandom);
        set_base(5'd16, with_byte(hex_lo, 5, 8'hff), hex_hi);
        send_value($urandom);
        set_base(5'd16, hex_lo, with_byte(hex_hi, 6, 8'h31));
        send_value($urandom);
    endtask

    task automatic test_random_bases();
        logic [7:0] tab[16];
        bit taken[256];
        logic [SYM_W-1:0] lo;
        logic [SYM_W-1:0] hi;
        int r;
        int size;
        int n;
        int i;
        int j;
        bit broken;
        logic [7:0] b;
        while (values_sent < RANDOM_ITEMS + 25)
        begin
            foreach (taken[k])
                taken[k] = 1'b0;
            foreach (tab[k])
                tab[k] = 8'($urandom_range(0, 255));
            r = $urandom_range(2, 16);
            size = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 31) : r;
            if (size > 16)
                r = 16;
            for (int k = 0; k < r; k++)
            begin
                do
                    b = 8'($urandom_range(33, 126));
                while (taken[b] || b == CHAR_PLUS || b == CHAR_MINUS);
                taken[b] = 1'b1;
                tab[k] = b;
            end
            broken = ($urandom_range(0, 7) == 0);
            if (broken)
            begin
                i = $urandom_range(0, r - 1);
                case ($urandom_range(0, 3))
                    0: size = $urandom_range(0, 1);
                    1:
                    begin
                        case ($urandom_range(0, 4))
                            0: tab[i] = CHAR_PLUS;
                            1: tab[i] = CHAR_MINUS;
                            2: tab[i] = 8'($urandom_range(0, 32));
                            3: tab[i] = CHAR_DEL;
                            default: tab[i] = 8'($urandom_range(128, 255));
                        endcase
                    end
                    default:
                    begin
                        do
                            j = $urandom_range(0, r - 1);
                        while (j == i);
                        tab[j] = tab[i];
                    end
                endcase
            end
            for (int k = 0; k < 8; k++)
            begin
                lo[k*8 +: 8] = tab[k];
                hi[k*8 +: 8] = tab[k+8];
            end
            set_base(RADIX_W'(size), lo, hi);
            // the final stretch runs without idling
            idle_on = (values_sent + 60 < RANDOM_ITEMS + 25) && ($urandom_range(0, 3) != 0);
            n = broken ? $urandom_range(3, 8) : $urandom_range(20, 45);
            if (n > RANDOM_ITEMS + 25 - values_sent)
                n = RANDOM_ITEMS + 25 - values_sent;
            repeat (n)
                send_value(pick_value(r));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        value = '0;
        wr_en = 1'b0;
        wr_index = REG_BASE_SIZE;
        wr_data = '0;
        cfg_size = BASE_SIZE_RESET;
        cfg_lo = SYMBOLS_LOW_RESET;
        cfg_hi = SYMBOLS_HIGH_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_base();
        test_radix_extremes();
        test_invalid_bases();
        test_random_bases();

        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("%0d values in %0d bases, %0d characters checked (%0d invalid-base items)",
                 values_sent, configs_used + 1, chars_seen, invalid_seen);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0 && pending_chars.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/rde_pkg.sv
sv/rde_front.sv
sv/rde_queue.sv
sv/rde_back.sv
sv/radix_digit_emitter.sv
bench/tb_radix_digit_emitter.sv
